// ===== design/lobm_pkg.sv =====
// shared types, constants and codes for the limit order book matcher
package lobm_pkg;

  // default book depth per side
  localparam int BOOK_DEPTH_DEF = 16;
  // most trades made while handling one item
  localparam int MAX_TRADES = 16;

  localparam int PRICE_W = 48;
  localparam int QTY_W   = 24;
  localparam int TOTAL_W = 32;
  localparam int NTR_W   = 5;

  // configuration register indexes
  localparam logic [1:0] CFG_MIN_UNIT  = 2'd0;
  localparam logic [1:0] CFG_MIN_TOTAL = 2'd1;

  // configuration reset values
  localparam logic [PRICE_W-1:0] MIN_UNIT_RST  = 48'd3276800;
  localparam logic [TOTAL_W-1:0] MIN_TOTAL_RST = 32'd100;

  // result kinds
  typedef enum logic [1:0] {
    KIND_REST    = 2'd0,
    KIND_TRADE   = 2'd1,
    KIND_INVALID = 2'd2,
    KIND_FULL    = 2'd3
  } kind_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_CHECK,
    S_REJECT,
    S_FIND,
    S_FIND_CMP,
    S_SHIFT,
    S_SHIFT_WR,
    S_MATCH_RD,
    S_MATCH_CMP,
    S_TRADE,
    S_MID,
    S_MUL,
    S_SUM
  } state_t;

  // per-side book control
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic pop;
    logic push;
  } book_ctl_t;

endpackage

// ===== design/lobm_div.sv =====
// serial restoring divider, one quotient bit per cycle
module lobm_div
  import lobm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [PRICE_W-1:0] dividend,
  input  logic [QTY_W-1:0]   divisor,
  output logic               done,
  output logic [PRICE_W-1:0] quotient
);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [5:0]         cnt_r, cnt_nxt;
  logic [PRICE_W-1:0] dvd_r, dvd_nxt;
  logic [QTY_W-1:0]   rem_r, rem_nxt;
  logic [QTY_W-1:0]   dvs_r, dvs_nxt;
  logic [QTY_W:0]     shifted;
  logic               ge;

  // one trial subtraction
  assign shifted = {rem_r, dvd_r[PRICE_W-1]};
  assign ge      = shifted >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 6'(PRICE_W);
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? QTY_W'(shifted - {1'b0, dvs_r}) : shifted[QTY_W-1:0];
      dvd_nxt = {dvd_r[PRICE_W-2:0], ge};
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

// ===== design/lobm_book.sv =====
// one side of the book: circular entry memory with head pointer and fill count
module lobm_book
  import lobm_pkg::*;
#(
  parameter int BOOK_DEPTH = BOOK_DEPTH_DEF,
  localparam int AW = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1,
  localparam int CW = $clog2(BOOK_DEPTH + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  book_ctl_t              ctl,
  input  logic [AW-1:0]          rd_idx,
  input  logic [AW-1:0]          wr_idx,
  input  logic [PRICE_W-1:0]     wr_price,
  input  logic [QTY_W-1:0]       wr_qty,
  output logic [PRICE_W-1:0]     rd_price,
  output logic [QTY_W-1:0]       rd_qty,
  output logic [CW-1:0]          count
);

  localparam int EW = PRICE_W + QTY_W;

  logic [EW-1:0] mem [BOOK_DEPTH];
  logic [EW-1:0] rd_data_r;
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] rd_phys, wr_phys;

  // logical position to memory address
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [AW-1:0] idx);
    logic [AW:0] sum;
    sum = {1'b0, head} + {1'b0, idx};
    if (sum >= (AW+1)'(BOOK_DEPTH)) sum = sum - (AW+1)'(BOOK_DEPTH);
    return sum[AW-1:0];
  endfunction

  assign rd_phys = phys(head_r, rd_idx);
  assign wr_phys = phys(head_r, wr_idx);

  // head and count updates
  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (ctl.pop) begin
      head_nxt  = (head_r == AW'(BOOK_DEPTH - 1)) ? '0 : head_r + AW'(1);
      count_nxt = count_r - CW'(1);
    end else if (ctl.push) begin
      count_nxt = count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  // entry memory
  always_ff @(posedge clk) begin
    if (ctl.wr_en) mem[wr_phys] <= {wr_price, wr_qty};
    if (ctl.rd_en) rd_data_r <= mem[rd_phys];
  end

  assign rd_price = rd_data_r[EW-1:QTY_W];
  assign rd_qty   = rd_data_r[QTY_W-1:0];
  assign count    = count_r;

endmodule

// ===== design/limit_order_book_matcher_top.sv =====
// Limit order book matcher: one buy or sell item in, one or more result items out.
// Each item's unit price is floor(total_price*65536/quantity), found by a serial
// divider at one quotient bit per cycle. The item is then checked, placed by
// price-time priority with a scan over the entries ahead of it and a shift of the
// entries behind it, and the book heads are matched, up to 16 trades. A zero
// quantity item skips the divider and is rejected. Result side stalls hold the
// item; the input stays stalled until the last result of the item is registered.
module limit_order_book_matcher_top
  import lobm_pkg::*;
#(
  parameter int BOOK_DEPTH = BOOK_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_req_type,
  input  logic [QTY_W-1:0]   in_quantity,
  input  logic [TOTAL_W-1:0] in_total_price,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_kind,
  output logic [QTY_W-1:0]   out_trade_quantity,
  output logic [TOTAL_W-1:0] out_trade_value,
  output logic [PRICE_W-1:0] out_buy_unit_price,
  output logic [PRICE_W-1:0] out_sell_unit_price,
  output logic [QTY_W-1:0]   out_remaining_quantity,
  output logic               out_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [PRICE_W-1:0] cfg_data
);

  localparam int AW = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
  localparam int CW = $clog2(BOOK_DEPTH + 1);

  state_t state_r, state_nxt;

  // configuration
  logic [PRICE_W-1:0] min_unit_r;
  logic [TOTAL_W-1:0] min_total_r;

  // item and work registers
  logic               req_buy_r;
  logic [QTY_W-1:0]   qty_r;
  logic [TOTAL_W-1:0] tp_r;
  logic [PRICE_W-1:0] up_r;
  logic [AW-1:0]      pos_r, idx_r;
  logic               inc_valid_r;
  logic [NTR_W-1:0]   ntr_r;
  kind_t              rej_kind_r;
  logic [PRICE_W-1:0] b_r, s_r, d_r, mid_r;
  logic [QTY_W-1:0]   bq_r, sq_r, tq_r;
  logic [55:0]        hi_r;
  logic [QTY_W-1:0]   lo_r;
  logic [39:0]        lo_prod;

  // pending trade result
  logic               pend_valid_r;
  logic [QTY_W-1:0]   pend_tq_r, pend_rem_r;
  logic [TOTAL_W-1:0] pend_tv_r;
  logic [PRICE_W-1:0] pend_b_r, pend_s_r;

  // output register
  logic               out_valid_r;
  kind_t              out_kind_r;
  logic [QTY_W-1:0]   out_tq_r, out_rem_r;
  logic [TOTAL_W-1:0] out_tv_r;
  logic [PRICE_W-1:0] out_bp_r, out_sp_r;
  logic               out_last_r;

  // book ports
  book_ctl_t          buy_ctl, sell_ctl;
  logic [AW-1:0]      buy_rd_idx, buy_wr_idx, sell_rd_idx, sell_wr_idx;
  logic [PRICE_W-1:0] buy_wr_price, sell_wr_price, buy_rd_price, sell_rd_price;
  logic [QTY_W-1:0]   buy_wr_qty, sell_wr_qty, buy_rd_qty, sell_rd_qty;
  logic [CW-1:0]      buy_count, sell_count, own_count;
  logic [PRICE_W-1:0] own_rd_price;
  logic [QTY_W-1:0]   own_rd_qty;

  // divider
  logic               div_start, div_done;
  logic [PRICE_W-1:0] div_quot;

  // decisions
  logic               accept, out_free, cont, need_push, go;
  logic               bad_price, own_full, brk;
  logic [QTY_W-1:0]   tq;
  logic               pop_b, pop_s;
  logic [56:0]        tv_sum;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  assign own_count    = req_buy_r ? buy_count : sell_count;
  assign own_rd_price = req_buy_r ? buy_rd_price : sell_rd_price;
  assign own_rd_qty   = req_buy_r ? buy_rd_qty : sell_rd_qty;

  assign bad_price = (up_r < min_unit_r) || (tp_r < min_total_r);
  assign own_full  = (own_count == CW'(BOOK_DEPTH));
  assign brk       = req_buy_r ? (up_r > own_rd_price) : (up_r < own_rd_price);

  // match loop test on the head entries
  assign cont      = (ntr_r < NTR_W'(MAX_TRADES)) && (buy_count != '0) &&
                     (sell_count != '0) && (buy_rd_price >= sell_rd_price);
  assign need_push = pend_valid_r || (!cont && ntr_r == '0);
  assign go        = !need_push || out_free;

  assign tq    = (bq_r < sq_r) ? bq_r : sq_r;
  assign pop_b = bq_r <= sq_r;
  assign pop_s = sq_r <= bq_r;

  // product of the midpoint's low 16 bits and the trade quantity
  assign lo_prod = 40'(mid_r[15:0]) * 40'(tq_r);

  assign tv_sum = {1'b0, hi_r} + 57'(lo_r);

  lobm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({in_total_price, 16'd0}),
    .divisor  (in_quantity),
    .done     (div_done),
    .quotient (div_quot)
  );

  lobm_book #(.BOOK_DEPTH(BOOK_DEPTH)) u_buy (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (buy_ctl),
    .rd_idx   (buy_rd_idx),
    .wr_idx   (buy_wr_idx),
    .wr_price (buy_wr_price),
    .wr_qty   (buy_wr_qty),
    .rd_price (buy_rd_price),
    .rd_qty   (buy_rd_qty),
    .count    (buy_count)
  );

  lobm_book #(.BOOK_DEPTH(BOOK_DEPTH)) u_sell (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (sell_ctl),
    .rd_idx   (sell_rd_idx),
    .wr_idx   (sell_wr_idx),
    .wr_price (sell_wr_price),
    .wr_qty   (sell_wr_qty),
    .rd_price (sell_rd_price),
    .rd_qty   (sell_rd_qty),
    .count    (sell_count)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = (in_quantity == '0) ? S_REJECT : S_DIV;
      end
      S_DIV: begin
        if (div_done) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        state_nxt = (bad_price || own_full) ? S_REJECT : S_FIND;
      end
      S_REJECT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      S_FIND: begin
        state_nxt = (CW'(pos_r) == own_count) ? S_SHIFT : S_FIND_CMP;
      end
      S_FIND_CMP: begin
        state_nxt = brk ? S_SHIFT : S_FIND;
      end
      S_SHIFT: begin
        state_nxt = (idx_r == pos_r) ? S_MATCH_RD : S_SHIFT_WR;
      end
      S_SHIFT_WR:  state_nxt = S_SHIFT;
      S_MATCH_RD:  state_nxt = S_MATCH_CMP;
      S_MATCH_CMP: begin
        if (go) state_nxt = cont ? S_TRADE : S_IDLE;
      end
      S_TRADE: state_nxt = S_MID;
      S_MID:   state_nxt = S_MUL;
      S_MUL:   state_nxt = S_SUM;
      S_SUM:   state_nxt = S_MATCH_RD;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control outputs toward the divider and the two book sides
  always_comb begin
    book_ctl_t          own_ctl;
    logic [AW-1:0]      own_rd_idx, own_wr_idx;
    logic [PRICE_W-1:0] own_wr_price;
    logic [QTY_W-1:0]   own_wr_qty;
    own_ctl      = '0;
    own_rd_idx   = '0;
    own_wr_idx   = '0;
    own_wr_price = up_r;
    own_wr_qty   = qty_r;
    div_start    = 1'b0;
    buy_ctl      = '0;
    sell_ctl     = '0;
    buy_rd_idx   = '0;
    sell_rd_idx  = '0;
    buy_wr_idx   = '0;
    sell_wr_idx  = '0;
    buy_wr_price = b_r;
    sell_wr_price = s_r;
    buy_wr_qty   = bq_r - tq;
    sell_wr_qty  = sq_r - tq;
    unique case (state_r)
      S_IDLE: begin
        div_start = accept && (in_quantity != '0);
      end
      S_FIND: begin
        own_ctl.rd_en = (CW'(pos_r) != own_count);
        own_rd_idx    = pos_r;
      end
      S_SHIFT: begin
        if (idx_r == pos_r) begin
          own_ctl.wr_en = 1'b1;
          own_ctl.push  = 1'b1;
          own_wr_idx    = pos_r;
        end else begin
          own_ctl.rd_en = 1'b1;
          own_rd_idx    = idx_r - AW'(1);
        end
      end
      S_SHIFT_WR: begin
        own_ctl.wr_en = 1'b1;
        own_wr_idx    = idx_r;
        own_wr_price  = own_rd_price;
        own_wr_qty    = own_rd_qty;
      end
      S_MUL: begin
        own_ctl.rd_en = 1'b1;
        own_rd_idx    = pos_r;
      end
      default: ;
    endcase
    // the insert path works on the item's own side only
    if (req_buy_r) begin
      if (own_ctl != '0) begin
        buy_ctl      = own_ctl;
        buy_rd_idx   = own_rd_idx;
        buy_wr_idx   = own_wr_idx;
        buy_wr_price = own_wr_price;
        buy_wr_qty   = own_wr_qty;
      end
    end else begin
      if (own_ctl != '0) begin
        sell_ctl      = own_ctl;
        sell_rd_idx   = own_rd_idx;
        sell_wr_idx   = own_wr_idx;
        sell_wr_price = own_wr_price;
        sell_wr_qty   = own_wr_qty;
      end
    end
    // head reads and head updates touch both sides
    if (state_r == S_MATCH_RD) begin
      buy_ctl.rd_en  = 1'b1;
      sell_ctl.rd_en = 1'b1;
    end
    if (state_r == S_TRADE) begin
      buy_ctl.wr_en  = !pop_b;
      buy_ctl.pop    = pop_b;
      sell_ctl.wr_en = !pop_s;
      sell_ctl.pop   = pop_s;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_unit_r  <= MIN_UNIT_RST;
      min_total_r <= MIN_TOTAL_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MIN_UNIT:  min_unit_r  <= cfg_data;
        CFG_MIN_TOTAL: min_total_r <= cfg_data[TOTAL_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_SHIFT:     if (idx_r == pos_r) pend_valid_r <= 1'b0;
        S_MATCH_CMP: if (go) pend_valid_r <= 1'b0;
        S_SUM:       pend_valid_r <= 1'b1;
        default: ;
      endcase
    end
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          req_buy_r  <= !in_req_type;
          qty_r      <= in_quantity;
          tp_r       <= in_total_price;
          rej_kind_r <= KIND_INVALID;
        end
      end
      S_DIV: begin
        if (div_done) up_r <= div_quot;
      end
      S_CHECK: begin
        rej_kind_r <= bad_price ? KIND_INVALID : KIND_FULL;
        pos_r      <= '0;
      end
      S_FIND: begin
        if (CW'(pos_r) == own_count) idx_r <= own_count[AW-1:0];
      end
      S_FIND_CMP: begin
        if (brk) idx_r <= own_count[AW-1:0];
        else     pos_r <= pos_r + AW'(1);
      end
      S_SHIFT: begin
        if (idx_r == pos_r) begin
          inc_valid_r <= 1'b1;
          ntr_r       <= '0;
        end
      end
      S_SHIFT_WR: idx_r <= idx_r - AW'(1);
      S_MATCH_CMP: begin
        b_r  <= buy_rd_price;
        s_r  <= sell_rd_price;
        bq_r <= buy_rd_qty;
        sq_r <= sell_rd_qty;
      end
      S_TRADE: begin
        tq_r <= tq;
        d_r  <= b_r - s_r;
        // track the incoming entry as heads leave its side
        if (inc_valid_r && (req_buy_r ? pop_b : pop_s)) begin
          if (pos_r == '0) inc_valid_r <= 1'b0;
          else             pos_r <= pos_r - AW'(1);
        end
      end
      S_MID: mid_r <= b_r - (d_r >> 1);
      S_MUL: begin
        hi_r <= mid_r[PRICE_W-1:16] * tq_r;
        lo_r <= lo_prod[39:16];
      end
      S_SUM: begin
        pend_tq_r  <= tq_r;
        pend_tv_r  <= (tv_sum > 57'hFFFF_FFFF) ? '1 : tv_sum[TOTAL_W-1:0];
        pend_b_r   <= b_r;
        pend_s_r   <= s_r;
        pend_rem_r <= inc_valid_r ? own_rd_qty : '0;
        ntr_r      <= ntr_r + NTR_W'(1);
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (((state_r == S_REJECT) && out_free) ||
                 ((state_r == S_MATCH_CMP) && go && need_push)) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if ((state_r == S_REJECT) && out_free) begin
      out_kind_r <= rej_kind_r;
      out_tq_r   <= '0;
      out_tv_r   <= '0;
      out_bp_r   <= '0;
      out_sp_r   <= '0;
      out_rem_r  <= '0;
      out_last_r <= 1'b1;
    end else if ((state_r == S_MATCH_CMP) && go && need_push) begin
      if (pend_valid_r) begin
        out_kind_r <= KIND_TRADE;
        out_tq_r   <= pend_tq_r;
        out_tv_r   <= pend_tv_r;
        out_bp_r   <= pend_b_r;
        out_sp_r   <= pend_s_r;
        out_rem_r  <= pend_rem_r;
        out_last_r <= !cont;
      end else begin
        out_kind_r <= KIND_REST;
        out_tq_r   <= '0;
        out_tv_r   <= '0;
        out_bp_r   <= req_buy_r ? up_r : '0;
        out_sp_r   <= req_buy_r ? '0 : up_r;
        out_rem_r  <= qty_r;
        out_last_r <= 1'b1;
      end
    end
  end

  assign out_valid              = out_valid_r;
  assign out_kind               = out_kind_r;
  assign out_trade_quantity     = out_tq_r;
  assign out_trade_value        = out_tv_r;
  assign out_buy_unit_price     = out_bp_r;
  assign out_sell_unit_price    = out_sp_r;
  assign out_remaining_quantity = out_rem_r;
  assign out_last               = out_last_r;

endmodule

// ===== test/limit_order_book_matcher_top_tb.sv =====
// testbench for the limit order book matcher with an order book predictor
module limit_order_book_matcher_top_tb;
  import lobm_pkg::*;

  localparam int DEPTH      = 16;
  localparam int CYCLE_CAP  = 1000000;
  localparam int DRAIN_WAIT = 300;

  // one expected result item
  typedef struct {
    kind_t              kind;
    logic [QTY_W-1:0]   tqty;
    logic [TOTAL_W-1:0] tval;
    logic [PRICE_W-1:0] bprice;
    logic [PRICE_W-1:0] sprice;
    logic [QTY_W-1:0]   rem;
    logic               last;
  } fill_t;

  // book predictor and store of expected fills
  class book_scoreboard;
    logic [PRICE_W-1:0] bid_px[DEPTH];
    logic [QTY_W-1:0]   bid_qty[DEPTH];
    logic [PRICE_W-1:0] ask_px[DEPTH];
    logic [QTY_W-1:0]   ask_qty[DEPTH];
    int                 bid_n;
    int                 ask_n;
    logic [PRICE_W-1:0] min_unit;
    logic [TOTAL_W-1:0] min_total;
    fill_t              fills[$];
    int                 errors;

    function new();
      bid_n = 0;
      ask_n = 0;
      min_unit = MIN_UNIT_RST;
      min_total = MIN_TOTAL_RST;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [PRICE_W-1:0] data);
      if (idx == CFG_MIN_UNIT) min_unit = data;
      else if (idx == CFG_MIN_TOTAL) min_total = data[TOTAL_W-1:0];
    endfunction

    function void push_fill(kind_t k, logic [QTY_W-1:0] tq, logic [TOTAL_W-1:0] tv,
                            logic [PRICE_W-1:0] bp, logic [PRICE_W-1:0] sp,
                            logic [QTY_W-1:0] rem);
      fill_t f;
      f.kind = k;
      f.tqty = tq;
      f.tval = tv;
      f.bprice = bp;
      f.sprice = sp;
      f.rem = rem;
      f.last = 1'b0;
      fills.push_back(f);
    endfunction

    // predict all result items caused by one accepted order
    function void note_order(logic sell, logic [QTY_W-1:0] qty, logic [TOTAL_W-1:0] tp);
      logic [63:0] up, mid, prod;
      logic [QTY_W-1:0] bq, sq, tq, rem;
      logic [PRICE_W-1:0] b, s;
      int pos, n, i;
      bit live, pop_b, pop_s;
      live = 1;
      n = 0;
      if (qty == 0) begin
        push_fill(KIND_INVALID, 0, 0, 0, 0, 0);
        fills[$].last = 1'b1;
        return;
      end
      up = ({32'd0, tp} << 16) / qty;
      if (up < min_unit || tp < min_total) begin
        push_fill(KIND_INVALID, 0, 0, 0, 0, 0);
        fills[$].last = 1'b1;
        return;
      end
      if ((sell ? ask_n : bid_n) >= DEPTH) begin
        push_fill(KIND_FULL, 0, 0, 0, 0, 0);
        fills[$].last = 1'b1;
        return;
      end
      // place by price then arrival
      pos = 0;
      if (!sell) begin
        while (pos < bid_n && !(up > bid_px[pos])) pos++;
        for (i = bid_n; i > pos; i--) begin
          bid_px[i] = bid_px[i-1];
          bid_qty[i] = bid_qty[i-1];
        end
        bid_px[pos] = up;
        bid_qty[pos] = qty;
        bid_n++;
      end else begin
        while (pos < ask_n && !(up < ask_px[pos])) pos++;
        for (i = ask_n; i > pos; i--) begin
          ask_px[i] = ask_px[i-1];
          ask_qty[i] = ask_qty[i-1];
        end
        ask_px[pos] = up;
        ask_qty[pos] = qty;
        ask_n++;
      end
      // match heads while the book crosses, up to MAX_TRADES trades
      while (n < MAX_TRADES && bid_n > 0 && ask_n > 0 && bid_px[0] >= ask_px[0]) begin
        b = bid_px[0];
        s = ask_px[0];
        mid = b - ((b - s) >> 1);
        bq = bid_qty[0];
        sq = ask_qty[0];
        tq = (bq < sq) ? bq : sq;
        pop_b = (bq <= sq);
        pop_s = (sq <= bq);
        if (!pop_b) bid_qty[0] = bq - tq;
        if (!pop_s) ask_qty[0] = sq - tq;
        if (pop_b) begin
          for (i = 1; i < bid_n; i++) begin
            bid_px[i-1] = bid_px[i];
            bid_qty[i-1] = bid_qty[i];
          end
          bid_n--;
        end
        if (pop_s) begin
          for (i = 1; i < ask_n; i++) begin
            ask_px[i-1] = ask_px[i];
            ask_qty[i-1] = ask_qty[i];
          end
          ask_n--;
        end
        if (live && ((!sell && pop_b) || (sell && pop_s))) begin
          if (pos == 0) live = 0;
          else pos--;
        end
        rem = !live ? '0 : (sell ? ask_qty[pos] : bid_qty[pos]);
        prod = (mid >> 16) * tq + (((mid & 64'hFFFF) * tq) >> 16);
        push_fill(KIND_TRADE, tq, (prod > 64'hFFFFFFFF) ? 32'hFFFFFFFF : prod[31:0],
                  b, s, rem);
        n++;
      end
      if (n == 0) push_fill(KIND_REST, 0, 0, sell ? '0 : up[47:0], sell ? up[47:0] : '0, qty);
      fills[$].last = 1'b1;
    endfunction

    function void cmp(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t mismatch %s: expected %0h actual %0h", $time, name, exp_v, act_v);
      end
    endfunction

    // check one result item against the oldest expectation
    function void check_fill(logic [1:0] k, logic [QTY_W-1:0] tq, logic [TOTAL_W-1:0] tv,
                             logic [PRICE_W-1:0] bp, logic [PRICE_W-1:0] sp,
                             logic [QTY_W-1:0] rem, logic last);
      fill_t f;
      if (fills.size() == 0) begin
        errors++;
        $display("%0t unexpected result item: kind %0d", $time, k);
        return;
      end
      f = fills.pop_front();
      cmp("kind", f.kind, k);
      cmp("trade_quantity", f.tqty, tq);
      cmp("trade_value", f.tval, tv);
      cmp("buy_unit_price", f.bprice, bp);
      cmp("sell_unit_price", f.sprice, sp);
      cmp("remaining_quantity", f.rem, rem);
      cmp("last", f.last, last);
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_req_type;
  logic [QTY_W-1:0]   in_quantity;
  logic [TOTAL_W-1:0] in_total_price;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         out_kind;
  logic [QTY_W-1:0]   out_trade_quantity;
  logic [TOTAL_W-1:0] out_trade_value;
  logic [PRICE_W-1:0] out_buy_unit_price;
  logic [PRICE_W-1:0] out_sell_unit_price;
  logic [QTY_W-1:0]   out_remaining_quantity;
  logic               out_last;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [PRICE_W-1:0] cfg_data;

  book_scoreboard sb = new();
  bit  quiet = 0;
  int  cycles = 0;
  int  bias = 50;

  limit_order_book_matcher_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_req_type(in_req_type),
    .in_quantity(in_quantity), .in_total_price(in_total_price),
    .out_valid(out_valid), .out_stall(out_stall), .out_kind(out_kind),
    .out_trade_quantity(out_trade_quantity), .out_trade_value(out_trade_value),
    .out_buy_unit_price(out_buy_unit_price), .out_sell_unit_price(out_sell_unit_price),
    .out_remaining_quantity(out_remaining_quantity), .out_last(out_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // clock
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("[limit_order_book_matcher_top] ERROR");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_fill(out_kind, out_trade_quantity, out_trade_value, out_buy_unit_price,
                    out_sell_unit_price, out_remaining_quantity, out_last);
  end

  // result side back-pressure in bursts
  initial begin
    out_stall = 0;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall = 1;
        repeat ($urandom_range(1, 19)) @(negedge clk);
        out_stall = 0;
      end
    end
  end

  // drive one order item and note it when accepted
  task automatic send_order(logic sell, logic [QTY_W-1:0] qty, logic [TOTAL_W-1:0] tp);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid = 0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_req_type = sell;
    in_quantity = qty;
    in_total_price = tp;
    in_valid = 1;
    do @(posedge clk); while (in_stall);
    sb.note_order(sell, qty, tp);
    @(negedge clk);
  endtask

  // order sized and priced per unit in cents
  task automatic send_priced(logic sell, int unit_c, int qty);
    send_order(sell, qty, unit_c * qty);
  endtask

  // wait until the block has delivered everything and gone idle
  task automatic drain();
    in_valid = 0;
    while (sb.fills.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [PRICE_W-1:0] data);
    cfg_index = idx;
    cfg_data = data;
    cfg_valid = 1;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  // random order item, mostly sane market orders
  task automatic random_order();
    int r, unit_c, qty;
    logic sell;
    r = $urandom_range(0, 99);
    sell = ($urandom_range(0, 99) >= bias);
    if (r < 4) send_order(sell, 0, $urandom);
    else if (r < 10) send_order($urandom_range(0, 1), $urandom_range(0, 9999999), $urandom);
    else if (r < 13) begin
      qty = $urandom_range(1000000, 9999999);
      send_order(sell, qty, $urandom_range(32'h8000_0000, 32'hFFFF_FFFF));
    end else begin
      unit_c = sell ? $urandom_range(960, 1060) : $urandom_range(940, 1040);
      qty = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3000) : $urandom_range(1, 40);
      send_priced(sell, unit_c, qty);
    end
  endtask

  task automatic random_run(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 20 == 0) bias = ($urandom_range(0, 2) == 0) ? 10 : ($urandom_range(0, 1) ? 50 : 90);
      random_order();
    end
  endtask

  // main sequence
  initial begin
    rst_n = 0;
    in_valid = 0;
    in_req_type = 0;
    in_quantity = '0;
    in_total_price = '0;
    cfg_valid = 0;
    cfg_index = CFG_MIN_UNIT;
    cfg_data = '0;
    repeat (11) @(negedge clk);
    rst_n = 1;

    // directed: rejects, rests, partial and multi fills, extremes
    send_order(0, 0, 1000);
    send_order(0, 10, 400);
    send_order(1, 1, 99);
    send_priced(0, 1000, 10);
    send_priced(0, 1200, 5);
    send_priced(1, 1000, 3);
    send_priced(1, 950, 20);
    send_order(1, 9999999, 32'hFFFF_FFFF);
    send_order(0, 9999999, 32'hFFFF_FFFF);
    // fill the buy side with equal prices, then overflow it
    for (int i = 0; i < 17; i++) send_priced(0, 60, 2);
    // one sell sweeps the whole buy side at the trade limit
    send_order(1, 40, 2000);
    drain();

    random_run(100);
    drain();

    write_reg(CFG_MIN_UNIT, '0);
    write_reg(CFG_MIN_TOTAL, '0);
    send_order(0, 5, 0);
    send_order(1, 5, 0);
    random_run(80);
    drain();

    write_reg(CFG_MIN_UNIT, 48'hFFFF_FFFF_FFFF);
    write_reg(CFG_MIN_TOTAL, 48'hFFFF_FFFF);
    send_order(0, 1, 32'hFFFF_FFFF);
    random_run(20);
    drain();

    write_reg(CFG_MIN_UNIT, 48'd500 << 16);
    write_reg(CFG_MIN_TOTAL, 48'd1000);
    random_run(60);
    quiet = 1;
    random_run(50);
    in_valid = 0;

    while (sb.fills.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[limit_order_book_matcher_top] OK");
    end else begin
      $display("[limit_order_book_matcher_top] ERROR");
    end
    $finish;
  end

endmodule

// ===== limit_order_book_matcher_top.f =====
design/lobm_pkg.sv
design/lobm_div.sv
design/lobm_book.sv
design/limit_order_book_matcher_top.sv
test/limit_order_book_matcher_top_tb.sv
